FILE: hw/rtl/cbps_pkg.sv
// shared types, constants and helpers for the cubic bezier path sampler
package cbps_pkg;

  localparam int PW = 24;
  localparam int CW = PW + 1;
  localparam int TW = 17;
  localparam int ONE_T = 65536;
  localparam int SQW = 52;
  localparam int LW = 32;
  localparam int REGW = 16;
  localparam int STW = 32;

  localparam int MAX_POINTS_DEF = 64;
  localparam int CHORDS_DEF = 10;

  localparam logic [REGW-1:0] SPACING_RST = 16'd1280;
  localparam logic [REGW-1:0] TIME_STEP_RST = 16'd10;

  localparam logic CFG_SAMPLE_SPACING = 1'b0;
  localparam logic CFG_TIME_STEP = 1'b1;

  typedef logic signed [CW-1:0] coord_t;
  typedef logic signed [PW-1:0] pix_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EVAL,
    ST_SQUARE,
    ST_SQRT,
    ST_DIV,
    ST_PUT
  } state_t;

  function automatic pix_t sat24(coord_t v);
    pix_t r;
    if (v > coord_t'(25'sd8388607)) begin
      r = 24'sh7FFFFF;
    end else if (v < -coord_t'(25'sd8388608)) begin
      r = 24'sh800000;
    end else begin
      r = v[PW-1:0];
    end
    return r;
  endfunction

endpackage

FILE: hw/rtl/cubic_bezier_path_sampler.sv
// cubic bezier path sampler: chord length, step division and de casteljau point emission
//
//  channel | direction | handshake          | payload
//  in      | input     | in_valid/in_stall  | anchor, handle, starts/ends flags
//  out     | output    | out_valid/out_stall| point x/y, time stamp, last flag
//  cfg     | input     | cfg_we             | cfg_index, cfg_wdata
//
// a segment anchor puts each chord point through the shared lerp unit, squares each chord
// and sums the square roots as the length, divides the spacing by it for the step, then
// evaluates and emits each point; a start anchor is stored, a single-anchor curve emitted
// reset clears control state and the stored anchor flag and restores the configuration defaults
// a stall on out holds the point register and the sequencer waits on the next point
module cubic_bezier_path_sampler #(
  parameter int MAX_POINTS = cbps_pkg::MAX_POINTS_DEF,
  parameter int CHORDS = cbps_pkg::CHORDS_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic signed [cbps_pkg::PW-1:0] in_anchor_x,
  input  logic signed [cbps_pkg::PW-1:0] in_anchor_y,
  input  logic signed [cbps_pkg::PW-1:0] in_handle_dx,
  input  logic signed [cbps_pkg::PW-1:0] in_handle_dy,
  input  logic                         in_starts_curve,
  input  logic                         in_ends_curve,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic signed [cbps_pkg::PW-1:0] out_x,
  output logic signed [cbps_pkg::PW-1:0] out_y,
  output logic [cbps_pkg::STW-1:0]     out_stamp_ms,
  output logic                         out_last_of_run,
  input  logic                         cfg_we,
  input  logic                         cfg_index,
  input  logic [cbps_pkg::REGW-1:0]    cfg_wdata
);
  import cbps_pkg::*;

  localparam int TQ = ONE_T / CHORDS;
  localparam int TR = ONE_T % CHORDS;
  localparam int MIN_STEP = (ONE_T + MAX_POINTS - 1) / MAX_POINTS;
  localparam int KW = $clog2(CHORDS + 1);
  localparam int RMW = $clog2(CHORDS) + 1;

  state_t state_r, state_nxt;

  logic [REGW-1:0] spacing_r, spacing_nxt;
  logic [REGW-1:0] tstep_r, tstep_nxt;
  pix_t prev_ax_r, prev_ax_nxt, prev_ay_r, prev_ay_nxt;
  pix_t prev_hx_r, prev_hx_nxt, prev_hy_r, prev_hy_nxt;
  logic have_prev_r, have_prev_nxt;
  logic [STW-1:0] tc_r, tc_nxt;

  coord_t c_r [2][4];
  coord_t c_nxt [2][4];
  coord_t tmp_r [2][5];
  coord_t tmp_nxt [2][5];
  coord_t q_r [2];
  coord_t q_nxt [2];
  coord_t p_r [2];
  coord_t p_nxt [2];

  logic [2:0] es_r, es_nxt;
  logic mode_r, mode_nxt;
  logic single_r, single_nxt;
  logic [KW-1:0] k_r, k_nxt;
  logic [TW-1:0] t_r, t_nxt;
  logic [RMW-1:0] trem_r, trem_nxt;
  logic [SQW-1:0] srem_r, srem_nxt, sres_r, sres_nxt, sbit_r, sbit_nxt;
  logic [LW-1:0] len_r, len_nxt;
  logic [LW:0] drem_r, drem_nxt;
  logic [LW-1:0] dvd_r, dvd_nxt, quo_r, quo_nxt;
  logic [5:0] dcnt_r, dcnt_nxt;
  logic [TW-1:0] step_r, step_nxt;

  logic out_valid_r, out_valid_nxt;
  pix_t out_x_r, out_x_nxt, out_y_r, out_y_nxt;
  logic [STW-1:0] stamp_r, stamp_nxt;
  logic last_r, last_nxt;

  coord_t la [2];
  coord_t lb [2];
  coord_t lr [2];
  logic signed [CW:0] diff [2];
  logic signed [CW:0] dd [2];
  logic signed [CW+1:0] ma [2];
  logic signed [CW+1:0] mb [2];
  logic signed [2*CW+3:0] prod [2];
  logic signed [2*CW+3:0] rnd [2];

  logic accept, put_go, sqrt_done, div_done, eval_last, chord_last, tlast;
  logic [SQW-1:0] strial;
  logic [LW:0] dsh;
  logic [RMW-1:0] trem_sum;
  logic [TW:0] tsum;
  logic [STW:0] tc_sum;

  assign accept = in_valid && !in_stall;
  assign put_go = !out_valid_r || !out_stall;
  assign sqrt_done = (sbit_r == '0);
  assign div_done = (dcnt_r == 6'(LW));
  assign eval_last = (es_r == 3'd5);
  assign chord_last = (k_r == KW'(CHORDS));
  assign strial = sres_r + sbit_r;
  assign dsh = {drem_r[LW-1:0], dvd_r[LW-1]};
  assign trem_sum = trem_r + RMW'(TR);
  assign tsum = {1'b0, t_r} + {1'b0, step_r};
  assign tlast = tsum[TW] | tsum[TW-1];
  assign tc_sum = {1'b0, tc_r} + {{(STW-REGW+1){1'b0}}, tstep_r};

  assign in_stall = (state_r != ST_IDLE);
  assign out_valid = out_valid_r;
  assign out_x = out_x_r;
  assign out_y = out_y_r;
  assign out_stamp_ms = stamp_r;
  assign out_last_of_run = last_r;

  // shared lerp / square unit, one lane per axis
  always_comb begin
    for (int l = 0; l < 2; l++) begin
      case (es_r)
        3'd0: begin la[l] = c_r[l][0]; lb[l] = c_r[l][1]; end
        3'd1: begin la[l] = c_r[l][1]; lb[l] = c_r[l][2]; end
        3'd2: begin la[l] = c_r[l][2]; lb[l] = c_r[l][3]; end
        3'd3: begin la[l] = tmp_r[l][0]; lb[l] = tmp_r[l][1]; end
        3'd4: begin la[l] = tmp_r[l][1]; lb[l] = tmp_r[l][2]; end
        default: begin la[l] = tmp_r[l][3]; lb[l] = tmp_r[l][4]; end
      endcase
      diff[l] = {lb[l][CW-1], lb[l]} - {la[l][CW-1], la[l]};
      dd[l] = {q_r[l][CW-1], q_r[l]} - {p_r[l][CW-1], p_r[l]};
      if (state_r == ST_SQUARE) begin
        ma[l] = {dd[l][CW], dd[l]};
        mb[l] = {dd[l][CW], dd[l]};
      end else begin
        ma[l] = {diff[l][CW], diff[l]};
        mb[l] = $signed({{(CW+2-TW){1'b0}}, t_r});
      end
      prod[l] = ma[l] * mb[l];
      rnd[l] = prod[l] + (2*CW+4)'(32768);
      lr[l] = la[l] + rnd[l][CW+15:16];
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          if (in_starts_curve || !have_prev_r) begin
            state_nxt = in_ends_curve ? ST_PUT : ST_IDLE;
          end else begin
            state_nxt = ST_EVAL;
          end
        end
      end
      ST_EVAL: begin
        if (eval_last) begin
          state_nxt = mode_r ? ST_PUT : ST_SQUARE;
        end
      end
      ST_SQUARE: state_nxt = ST_SQRT;
      ST_SQRT: begin
        if (sqrt_done) begin
          state_nxt = chord_last ? ST_DIV : ST_EVAL;
        end
      end
      ST_DIV: begin
        if (div_done) begin
          state_nxt = ST_EVAL;
        end
      end
      ST_PUT: begin
        if (put_go) begin
          state_nxt = (single_r || tlast) ? ST_IDLE : ST_EVAL;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    spacing_nxt = spacing_r;
    tstep_nxt = tstep_r;
    prev_ax_nxt = prev_ax_r;
    prev_ay_nxt = prev_ay_r;
    prev_hx_nxt = prev_hx_r;
    prev_hy_nxt = prev_hy_r;
    have_prev_nxt = have_prev_r;
    tc_nxt = tc_r;
    c_nxt = c_r;
    tmp_nxt = tmp_r;
    q_nxt = q_r;
    p_nxt = p_r;
    es_nxt = es_r;
    mode_nxt = mode_r;
    single_nxt = single_r;
    k_nxt = k_r;
    t_nxt = t_r;
    trem_nxt = trem_r;
    srem_nxt = srem_r;
    sres_nxt = sres_r;
    sbit_nxt = sbit_r;
    len_nxt = len_r;
    drem_nxt = drem_r;
    dvd_nxt = dvd_r;
    quo_nxt = quo_r;
    dcnt_nxt = dcnt_r;
    step_nxt = step_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_x_nxt = out_x_r;
    out_y_nxt = out_y_r;
    stamp_nxt = stamp_r;
    last_nxt = last_r;

    if (cfg_we) begin
      case (cfg_index)
        CFG_SAMPLE_SPACING: spacing_nxt = cfg_wdata;
        CFG_TIME_STEP: tstep_nxt = cfg_wdata;
        default: ;
      endcase
    end

    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          c_nxt[0][0] = CW'(prev_ax_r);
          c_nxt[1][0] = CW'(prev_ay_r);
          c_nxt[0][1] = CW'(prev_ax_r) - CW'(prev_hx_r);
          c_nxt[1][1] = CW'(prev_ay_r) - CW'(prev_hy_r);
          c_nxt[0][2] = CW'(in_anchor_x) + CW'(in_handle_dx);
          c_nxt[1][2] = CW'(in_anchor_y) + CW'(in_handle_dy);
          c_nxt[0][3] = CW'(in_anchor_x);
          c_nxt[1][3] = CW'(in_anchor_y);
          p_nxt[0] = CW'(prev_ax_r);
          p_nxt[1] = CW'(prev_ay_r);
          q_nxt[0] = CW'(in_anchor_x);
          q_nxt[1] = CW'(in_anchor_y);
          prev_ax_nxt = in_anchor_x;
          prev_ay_nxt = in_anchor_y;
          prev_hx_nxt = in_handle_dx;
          prev_hy_nxt = in_handle_dy;
          have_prev_nxt = !in_ends_curve;
          single_nxt = in_starts_curve || !have_prev_r;
          if (in_starts_curve || !have_prev_r) begin
            tc_nxt = '0;
          end
          mode_nxt = 1'b0;
          es_nxt = '0;
          k_nxt = KW'(1);
          t_nxt = TW'(TQ);
          trem_nxt = RMW'(TR);
          len_nxt = '0;
        end
      end
      ST_EVAL: begin
        for (int l = 0; l < 2; l++) begin
          case (es_r)
            3'd0: tmp_nxt[l][0] = lr[l];
            3'd1: tmp_nxt[l][1] = lr[l];
            3'd2: tmp_nxt[l][2] = lr[l];
            3'd3: tmp_nxt[l][3] = lr[l];
            3'd4: tmp_nxt[l][4] = lr[l];
            default: q_nxt[l] = lr[l];
          endcase
        end
        es_nxt = eval_last ? 3'd0 : es_r + 3'd1;
      end
      ST_SQUARE: begin
        srem_nxt = SQW'(prod[0]) + SQW'(prod[1]);
        sres_nxt = '0;
        sbit_nxt = SQW'(1) << (SQW - 2);
      end
      ST_SQRT: begin
        if (!sqrt_done) begin
          if (srem_r >= strial) begin
            srem_nxt = srem_r - strial;
            sres_nxt = (sres_r >> 1) + sbit_r;
          end else begin
            sres_nxt = sres_r >> 1;
          end
          sbit_nxt = sbit_r >> 2;
        end else begin
          len_nxt = len_r + LW'(sres_r);
          p_nxt = q_r;
          k_nxt = k_r + KW'(1);
          if (trem_sum >= RMW'(CHORDS)) begin
            t_nxt = t_r + TW'(TQ + 1);
            trem_nxt = trem_sum - RMW'(CHORDS);
          end else begin
            t_nxt = t_r + TW'(TQ);
            trem_nxt = trem_sum;
          end
          drem_nxt = '0;
          dvd_nxt = {spacing_r, 16'd0};
          dcnt_nxt = '0;
        end
      end
      ST_DIV: begin
        if (!div_done) begin
          if (dsh >= {1'b0, len_r}) begin
            drem_nxt = dsh - {1'b0, len_r};
            quo_nxt = {quo_r[LW-2:0], 1'b1};
          end else begin
            drem_nxt = dsh;
            quo_nxt = {quo_r[LW-2:0], 1'b0};
          end
          dvd_nxt = dvd_r << 1;
          dcnt_nxt = dcnt_r + 6'd1;
        end else begin
          if (quo_r > LW'(ONE_T)) begin
            step_nxt = TW'(ONE_T);
          end else if (quo_r < LW'(MIN_STEP)) begin
            step_nxt = TW'(MIN_STEP);
          end else begin
            step_nxt = quo_r[TW-1:0];
          end
          t_nxt = '0;
          mode_nxt = 1'b1;
          es_nxt = '0;
        end
      end
      ST_PUT: begin
        if (put_go) begin
          out_valid_nxt = 1'b1;
          out_x_nxt = sat24(q_r[0]);
          out_y_nxt = sat24(q_r[1]);
          stamp_nxt = tc_r;
          last_nxt = single_r || tlast;
          tc_nxt = tc_sum[STW] ? {STW{1'b1}} : tc_sum[STW-1:0];
          t_nxt = tsum[TW-1:0];
          es_nxt = '0;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      spacing_r <= SPACING_RST;
      tstep_r <= TIME_STEP_RST;
      prev_ax_r <= '0;
      prev_ay_r <= '0;
      prev_hx_r <= '0;
      prev_hy_r <= '0;
      have_prev_r <= 1'b0;
      tc_r <= '0;
      es_r <= '0;
      mode_r <= 1'b0;
      single_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      spacing_r <= spacing_nxt;
      tstep_r <= tstep_nxt;
      prev_ax_r <= prev_ax_nxt;
      prev_ay_r <= prev_ay_nxt;
      prev_hx_r <= prev_hx_nxt;
      prev_hy_r <= prev_hy_nxt;
      have_prev_r <= have_prev_nxt;
      tc_r <= tc_nxt;
      es_r <= es_nxt;
      mode_r <= mode_nxt;
      single_r <= single_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    c_r <= c_nxt;
    tmp_r <= tmp_nxt;
    q_r <= q_nxt;
    p_r <= p_nxt;
    k_r <= k_nxt;
    t_r <= t_nxt;
    trem_r <= trem_nxt;
    srem_r <= srem_nxt;
    sres_r <= sres_nxt;
    sbit_r <= sbit_nxt;
    len_r <= len_nxt;
    drem_r <= drem_nxt;
    dvd_r <= dvd_nxt;
    quo_r <= quo_nxt;
    dcnt_r <= dcnt_nxt;
    step_r <= step_nxt;
    out_x_r <= out_x_nxt;
    out_y_r <= out_y_nxt;
    stamp_r <= stamp_nxt;
    last_r <= last_nxt;
  end

endmodule

FILE: test/cubic_bezier_path_sampler_tb.sv
// testbench for the cubic bezier path sampler: directed and random curves checked against a point predictor
module cubic_bezier_path_sampler_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import cbps_pkg::*;

  typedef struct {
    pix_t x;
    pix_t y;
    logic [STW-1:0] stamp;
    logic last;
  } point_t;

  class bezier_point_board;
    point_t pending[$];
    int errors;
    logic [REGW-1:0] spacing;
    logic [REGW-1:0] tstep;
    longint ax_q, ay_q, hx_q, hy_q;
    bit held;
    logic [31:0] clock_ms;

    function new();
      spacing = SPACING_RST;
      tstep = TIME_STEP_RST;
      held = 0;
      clock_ms = 0;
      ax_q = 0; ay_q = 0; hx_q = 0; hy_q = 0;
      errors = 0;
    endfunction

    function void set_reg(logic idx, logic [REGW-1:0] v);
      if (idx == CFG_SAMPLE_SPACING) spacing = v;
      else tstep = v;
    endfunction

    function longint mix(longint a, longint b, longint t);
      return (a * (65536 - t) + b * t + 32768) >>> 16;
    endfunction

    function longint bez(longint c0, longint c1, longint c2, longint c3, longint t);
      longint a, b, d;
      a = mix(c0, c1, t);
      b = mix(c1, c2, t);
      d = mix(c2, c3, t);
      return mix(mix(a, b, t), mix(b, d, t), t);
    endfunction

    function longint unsigned root(longint unsigned v);
      longint unsigned r, bt;
      r = 0;
      bt = 64'd1 << 62;
      while (bt > v) bt >>= 2;
      while (bt != 0) begin
        if (v >= r + bt) begin
          v -= r + bt;
          r = (r >> 1) + bt;
        end else begin
          r >>= 1;
        end
        bt >>= 2;
      end
      return r;
    endfunction

    function pix_t clip(longint v);
      if (v > 8388607) v = 8388607;
      if (v < -8388608) v = -8388608;
      return pix_t'(v);
    endfunction

    function void push_point(longint x, longint y);
      point_t p;
      logic [32:0] nt;
      p.x = clip(x);
      p.y = clip(y);
      p.stamp = clock_ms;
      p.last = 0;
      pending.push_back(p);
      nt = {1'b0, clock_ms} + tstep;
      clock_ms = nt[32] ? 32'hFFFFFFFF : nt[31:0];
    endfunction

    function void note_anchor(pix_t ax, pix_t ay, pix_t hx, pix_t hy, bit s, bit e);
      longint cx0, cx1, cx2, cx3, cy0, cy1, cy2, cy3, px, py, qx, qy, dx, dy, t;
      longint unsigned len, stp;
      int n;
      n = 0;
      if (s || !held) begin
        clock_ms = 0;
        if (e) begin
          push_point(ax, ay);
          n = 1;
        end
      end else begin
        cx0 = ax_q; cy0 = ay_q;
        cx1 = ax_q - hx_q; cy1 = ay_q - hy_q;
        cx2 = longint'(ax) + hx; cy2 = longint'(ay) + hy;
        cx3 = ax; cy3 = ay;
        px = bez(cx0, cx1, cx2, cx3, 0);
        py = bez(cy0, cy1, cy2, cy3, 0);
        len = 0;
        for (int k = 1; k <= CHORDS_DEF; k++) begin
          t = (k * 65536) / CHORDS_DEF;
          qx = bez(cx0, cx1, cx2, cx3, t);
          qy = bez(cy0, cy1, cy2, cy3, t);
          dx = qx >= px ? qx - px : px - qx;
          dy = qy >= py ? qy - py : py - qy;
          len += root(dx * dx + dy * dy);
          px = qx;
          py = qy;
        end
        stp = len == 0 ? 65536 : ({48'd0, spacing} << 16) / len;
        if (stp < (65536 + MAX_POINTS_DEF - 1) / MAX_POINTS_DEF)
          stp = (65536 + MAX_POINTS_DEF - 1) / MAX_POINTS_DEF;
        if (stp > 65536) stp = 65536;
        for (t = 0; t < 65536 && n < MAX_POINTS_DEF; t += stp) begin
          push_point(bez(cx0, cx1, cx2, cx3, t), bez(cy0, cy1, cy2, cy3, t));
          n++;
        end
      end
      if (n > 0) pending[$].last = 1;
      ax_q = ax; ay_q = ay; hx_q = hx; hy_q = hy;
      held = !e;
    endfunction

    task report(string what, longint got, longint want);
      $display("mismatch %s: got %0h expected %0h", what, got, want);
      errors++;
    endtask

    task check_point(pix_t x, pix_t y, logic [STW-1:0] stamp, logic last);
      point_t p;
      if (pending.size() == 0) begin
        report("unexpected transaction", x, 0);
      end else begin
        p = pending.pop_front();
        if (x !== p.x) report("out_x", x, p.x);
        if (y !== p.y) report("out_y", y, p.y);
        if (stamp !== p.stamp) report("out_stamp_ms", stamp, p.stamp);
        if (last !== p.last) report("out_last_of_run", last, p.last);
      end
    endtask
  endclass

  logic clk = 0;
  logic rst_n = 0;
  logic in_valid = 0;
  logic in_stall;
  pix_t in_anchor_x = 0, in_anchor_y = 0, in_handle_dx = 0, in_handle_dy = 0;
  logic in_starts_curve = 0, in_ends_curve = 0;
  logic out_valid;
  logic out_stall = 0;
  pix_t out_x, out_y;
  logic [STW-1:0] out_stamp_ms;
  logic out_last_of_run;
  logic cfg_we = 0;
  logic cfg_index = 0;
  logic [REGW-1:0] cfg_wdata = 0;

  bezier_point_board sb = new();
  int send_pct = 0;
  int stall_pct = 0;
  int sent = 0;
  int quiet = 0;

  cubic_bezier_path_sampler uut (.*);

  always #1 clk = ~clk;

  always @(posedge clk) begin
    if (out_valid && !out_stall)
      sb.check_point(out_x, out_y, out_stamp_ms, out_last_of_run);
    out_stall <= ($urandom_range(99) < stall_pct);
  end

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || cfg_we) quiet <= 0;
    else quiet <= quiet + 1;
    if (quiet > 20000) begin
      $display("tb: failure");
      $finish;
    end
  end

  task automatic send(pix_t ax, pix_t ay, pix_t hx, pix_t hy, bit s, bit e);
    while ($urandom_range(99) < send_pct) begin
      in_valid <= 0;
      @(posedge clk);
    end
    in_valid <= 1;
    in_anchor_x <= ax;
    in_anchor_y <= ay;
    in_handle_dx <= hx;
    in_handle_dy <= hy;
    in_starts_curve <= s;
    in_ends_curve <= e;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sb.note_anchor(ax, ay, hx, hy, s, e);
    sent++;
  endtask

  task automatic drain();
    in_valid <= 0;
    @(posedge clk);
    while (sb.pending.size() > 0) @(posedge clk);
  endtask

  task automatic write_reg(logic idx, logic [REGW-1:0] v);
    drain();
    repeat (50) @(posedge clk);
    cfg_we <= 1;
    cfg_index <= idx;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we <= 0;
    sb.set_reg(idx, v);
  endtask

  function automatic pix_t near(pix_t base, int bits);
    return pix_t'(longint'(base) + $signed($urandom_range((1 << bits) - 1)) - (1 << (bits - 1)));
  endfunction

  task automatic random_curve();
    pix_t bx, by;
    int segs, bits;
    bits = $urandom_range(9, 17);
    bx = pix_t'($urandom);
    by = pix_t'($urandom);
    if ($urandom_range(99) < 15) begin
      send(pix_t'($urandom), pix_t'($urandom), pix_t'($urandom), pix_t'($urandom),
           $urandom_range(1), $urandom_range(1));
    end else begin
      segs = $urandom_range(0, 5);
      send(bx, by, near(0, bits), near(0, bits), 1, segs == 0);
      for (int i = 1; i <= segs; i++) begin
        bx = near(bx, bits);
        by = near(by, bits);
        send(bx, by, near(0, bits), near(0, bits), 0, i == segs);
      end
    end
  endtask

  initial begin
    repeat (6) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);
    // no stored anchor yet, so a non-start anchor begins the curve
    send(24'sh000100, 24'sh000200, 24'sh000300, 24'sh000400, 0, 0);
    send(24'sh000900, 24'sh000200, 24'sh000100, 24'sh000080, 0, 0);
    send(24'sh7FFFFF, 24'sh800000, 24'sh800000, 24'sh7FFFFF, 0, 1);
    // single-anchor curves at the extremes
    send(24'sh7FFFFF, 24'sh7FFFFF, 24'sh7FFFFF, 24'sh800000, 1, 1);
    send(24'sh800000, 24'sh800000, 24'sh000000, 24'sh000000, 1, 1);
    // zero-length segment
    send(24'sh001000, 24'sh001000, 0, 0, 1, 0);
    send(24'sh001000, 24'sh001000, 0, 0, 0, 1);
    // handles push control points past the coordinate range
    send(24'sh7FFF00, 24'sh800100, 24'sh800000, 24'sh7FFFFF, 1, 0);
    send(24'sh7FF000, 24'sh801000, 24'sh7FFFFF, 24'sh800000, 0, 0);
    send(24'sh000000, 24'sh000000, 24'shFFFFFF, 24'sh555555, 0, 1);
    write_reg(CFG_SAMPLE_SPACING, 16'd0);
    write_reg(CFG_TIME_STEP, 16'hFFFF);
    send(24'sh000000, 24'sh000000, 24'sh0000AA, 24'shFFFF55, 1, 0);
    send(24'sh002000, 24'sh001000, 24'sh000100, 24'sh000100, 0, 0);
    send(24'sh003000, 24'shFFF000, 24'sh000000, 24'sh000000, 1, 0);
    send(24'sh004000, 24'shFFE000, 24'sh000000, 24'sh000000, 0, 1);
    write_reg(CFG_SAMPLE_SPACING, 16'hFFFF);
    write_reg(CFG_TIME_STEP, 16'd0);
    send(24'sh000000, 24'sh000000, 24'sh000100, 24'sh000000, 1, 0);
    send(24'sh000800, 24'sh000800, 24'sh000100, 24'sh000000, 0, 1);
    for (int ph = 0; ph < 8; ph++) begin
      case (ph % 4)
        0: begin
          send_pct = 0; stall_pct = 0;
        end
        1: begin
          send_pct = 46; stall_pct = 0;
        end
        2: begin
          send_pct = 0; stall_pct = 46;
        end
        default: begin
          send_pct = 14; stall_pct = 14;
        end
      endcase
      case (ph)
        0: write_reg(CFG_SAMPLE_SPACING, 16'd1280);
        1: write_reg(CFG_TIME_STEP, 16'd10);
        2: write_reg(CFG_SAMPLE_SPACING, 16'd1);
        4: write_reg(CFG_SAMPLE_SPACING, 16'hFFFF);
        5: write_reg(CFG_TIME_STEP, 16'hFFFF);
        6: write_reg(CFG_SAMPLE_SPACING, 16'($urandom_range(1, 4000)));
        default: write_reg(CFG_TIME_STEP, 16'($urandom));
      endcase
      while (sent < 18 + 37 * (ph + 1)) begin
        random_curve();
        if (ph == 3 && $urandom_range(9) == 0) drain();
      end
    end
    drain();
    repeat (1000) @(posedge clk);
    if (sb.errors == 0) $display("tb: success");
    else $display("tb: failure");
    $finish;
  end
endmodule
